/* hdl/cds_pkg.sv */
`default_nettype none

package cds_pkg;

    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int YEAR_W  = 12;
    localparam int COUNT_W = 16;
    localparam int STAT_W  = 3;

    // command codes, value three is unused and ignored
    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_ADVANCE = 2'd1,
        CMD_BACK    = 2'd2
    } t_cmd;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_MONTH = 3'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_YEAR  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_BAD_DAY   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_LIMIT     = 3'd4;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [DAY_W-1:0]   DAY_LEAP  = 5'd29;
    localparam logic [DAY_W-1:0]   DAY_DEC31 = 5'd31;

    localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    typedef struct packed {
        logic [1:0]         command;
        logic [MONTH_W-1:0] load_month;
        logic [DAY_W-1:0]   load_day;
        logic [YEAR_W-1:0]  load_year;
        logic [COUNT_W-1:0] day_count;
    } t_in;

    typedef struct packed {
        logic [MONTH_W-1:0] month_now;
        logic [DAY_W-1:0]   day_now;
        logic [YEAR_W-1:0]  year_now;
        logic [STAT_W-1:0]  status;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic step;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_run;
        logic last;
    } t_dp_sts;

    // multiple of 100: compare against every century that fits in the year field
    function automatic logic is_century(input logic [YEAR_W-1:0] y);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k <= 40; k++) begin
            if (y == YEAR_W'(k * 100)) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // 400 = 16 * 25, so a century is a 400 multiple when its low four bits are zero
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic div4;
        div4 = (y[1:0] == 2'b00);
        return div4 && (!is_century(y) || (y[3:0] == 4'h0));
    endfunction

    function automatic logic [DAY_W-1:0] days_in(
        input logic [MONTH_W-1:0] m,
        input logic [YEAR_W-1:0]  y
    );
        logic [DAY_W-1:0] len;
        len = MONTH_LEN[m];
        if ((m == MONTH_FEB) && is_leap(y)) begin
            len = DAY_LEAP;
        end
        return len;
    endfunction

endpackage

`default_nettype wire

/* hdl/calendar_date_stepper_unit.sv */
// Gregorian date counter. Holds month, day and year (reset: 1 January of FIRST_YEAR) and
// answers one command beat with one result beat carrying the date after the command and a
// status. A load checks month, then year, then day, and keeps the old date on any error.
// Advance and back walk the date one day per clock through a single step unit using the
// month-length table and the 400/100/4 leap rule; a walk that would leave FIRST_YEAR..
// LAST_YEAR stops at the limit with status 4. Only the low COUNT_BITS bits of day_count are
// used. A command is taken in idle, walks its day count in the run state (a load, a zero
// count and the unused command skip the walk), and its result is written to the output
// register in the finish state once that register is free; a year limit ends the walk
// early. A new beat is taken as soon as the previous result is in the output register,
// even while that result is still stalled.
`default_nettype none

module calendar_date_stepper_unit #(
    parameter int FIRST_YEAR = 1900,
    parameter int LAST_YEAR  = 2100,
    parameter int COUNT_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire cds_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output cds_pkg::t_out      o_out_data
);

    cds_pkg::t_dp_cmd dp_cmd;
    cds_pkg::t_dp_sts dp_sts;

    cds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (dp_cmd)
    );

    cds_datapath #(
        .FIRST_YEAR (FIRST_YEAR),
        .LAST_YEAR  (LAST_YEAR),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in_data),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .o_out   (o_out_data)
    );

endmodule

`default_nettype wire

/* hdl/cds_datapath.sv */
`default_nettype none

module cds_datapath #(
    parameter int FIRST_YEAR = 1900,
    parameter int LAST_YEAR  = 2100,
    parameter int COUNT_BITS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire cds_pkg::t_in   i_in,
    input  wire cds_pkg::t_dp_cmd i_cmd,
    output cds_pkg::t_dp_sts    o_sts,
    output cds_pkg::t_out       o_out
);

    localparam int CNT_W = (COUNT_BITS < cds_pkg::COUNT_W) ? COUNT_BITS : cds_pkg::COUNT_W;
    localparam logic [cds_pkg::YEAR_W-1:0] Y_FIRST = cds_pkg::YEAR_W'(FIRST_YEAR);
    localparam logic [cds_pkg::YEAR_W-1:0] Y_LAST  = cds_pkg::YEAR_W'(LAST_YEAR);

    logic [cds_pkg::MONTH_W-1:0] r_month, n_month;
    logic [cds_pkg::DAY_W-1:0]   r_day, n_day;
    logic [cds_pkg::YEAR_W-1:0]  r_year, n_year;
    logic [cds_pkg::STAT_W-1:0]  r_status, n_status;
    logic [CNT_W-1:0]            r_count, n_count;
    logic                        r_back, n_back;
    cds_pkg::t_out               r_out;

    logic [cds_pkg::MONTH_W-1:0] s_month;
    logic [cds_pkg::DAY_W-1:0]   s_day;
    logic [cds_pkg::YEAR_W-1:0]  s_year;
    logic                        s_blocked;
    logic [CNT_W-1:0]            in_count;

    assign in_count = i_in.day_count[CNT_W-1:0];

    // one day forward or back from the held date
    always_comb begin
        s_month   = r_month;
        s_day     = r_day;
        s_year    = r_year;
        s_blocked = 1'b0;
        if (!r_back) begin
            if (r_day < cds_pkg::days_in(r_month, r_year)) begin
                s_day = r_day + 1'b1;
            end else if (r_month < cds_pkg::MONTH_DEC) begin
                s_month = r_month + 1'b1;
                s_day   = cds_pkg::DAY_FIRST;
            end else if (r_year >= Y_LAST) begin
                s_blocked = 1'b1;
            end else begin
                s_year  = r_year + 1'b1;
                s_month = cds_pkg::MONTH_JAN;
                s_day   = cds_pkg::DAY_FIRST;
            end
        end else begin
            if (r_day > cds_pkg::DAY_FIRST) begin
                s_day = r_day - 1'b1;
            end else if (r_month > cds_pkg::MONTH_JAN) begin
                s_month = r_month - 1'b1;
                s_day   = cds_pkg::days_in(r_month - 1'b1, r_year);
            end else if (r_year <= Y_FIRST) begin
                s_blocked = 1'b1;
            end else begin
                s_year  = r_year - 1'b1;
                s_month = cds_pkg::MONTH_DEC;
                s_day   = cds_pkg::DAY_DEC31;
            end
        end
    end

    always_comb begin
        n_month  = r_month;
        n_day    = r_day;
        n_year   = r_year;
        n_status = r_status;
        n_count  = r_count;
        n_back   = r_back;
        if (i_cmd.start) begin
            n_status = cds_pkg::STAT_OK;
            n_count  = in_count;
            n_back   = (i_in.command == cds_pkg::CMD_BACK);
            if (i_in.command == cds_pkg::CMD_LOAD) begin
                priority if ((i_in.load_month < cds_pkg::MONTH_JAN) ||
                             (i_in.load_month > cds_pkg::MONTH_DEC)) begin
                    n_status = cds_pkg::STAT_BAD_MONTH;
                end else if ((i_in.load_year < Y_FIRST) || (i_in.load_year > Y_LAST)) begin
                    n_status = cds_pkg::STAT_BAD_YEAR;
                end else if ((i_in.load_day < cds_pkg::DAY_FIRST) ||
                             (i_in.load_day >
                              cds_pkg::days_in(i_in.load_month, i_in.load_year))) begin
                    n_status = cds_pkg::STAT_BAD_DAY;
                end else begin
                    n_month = i_in.load_month;
                    n_day   = i_in.load_day;
                    n_year  = i_in.load_year;
                end
            end
        end else if (i_cmd.step) begin
            n_count = r_count - 1'b1;
            if (s_blocked) begin
                n_status = cds_pkg::STAT_LIMIT;
            end else begin
                n_month = s_month;
                n_day   = s_day;
                n_year  = s_year;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_month <= cds_pkg::MONTH_JAN;
            r_day   <= cds_pkg::DAY_FIRST;
            r_year  <= Y_FIRST;
        end else begin
            r_month <= n_month;
            r_day   <= n_day;
            r_year  <= n_year;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_count  <= n_count;
        r_back   <= n_back;
        if (i_cmd.emit) begin
            r_out.month_now <= r_month;
            r_out.day_now   <= r_day;
            r_out.year_now  <= r_year;
            r_out.status    <= r_status;
        end
    end

    assign o_sts.need_run = ((i_in.command == cds_pkg::CMD_ADVANCE) ||
                             (i_in.command == cds_pkg::CMD_BACK)) &&
                            (in_count != '0);
    assign o_sts.last     = s_blocked || (r_count == CNT_W'(1));
    assign o_out          = r_out;

endmodule

`default_nettype wire

/* hdl/cds_ctrl.sv */
`default_nettype none

module cds_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_out_stall,
    input  wire cds_pkg::t_dp_sts i_sts,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output cds_pkg::t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // output register can take a new beat when empty or being drained
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd.start = (r_state == S_IDLE) && i_in_valid;
        o_cmd.step  = (r_state == S_RUN);
        o_cmd.emit  = (r_state == S_FIN) && out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.need_run ? S_RUN : S_FIN;
                end
            end
            S_RUN: begin
                if (i_sts.last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* hdl/cds_checker.sv */
`default_nettype none

module cds_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_stall,
    input wire cds_pkg::t_in  i_in_data,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire cds_pkg::t_out o_out_data
);

    // no result beat straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a taken command keeps the input side stalled on the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second command taken while one in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result beat changed");

    // result date has a month of 1 to 12 and a day of at least 1
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.month_now >= 4'd1) && (o_out_data.month_now <= 4'd12) &&
                         (o_out_data.day_now >= 5'd1)))
        else $error("result date out of range");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status <= cds_pkg::STAT_LIMIT))
        else $error("unknown status code");

endmodule

bind calendar_date_stepper_unit cds_checker u_cds_checker (.*);

`default_nettype wire

/* dv/calendar_date_stepper_unit_tb.sv */
`timescale 1ns / 1ps

module calendar_date_stepper_unit_tb;

    localparam int FIRST_YEAR  = 1900;
    localparam int LAST_YEAR   = 2100;
    localparam int MAX_COUNT   = 65535;
    localparam int HOLD_CYCLES = 400;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    cds_pkg::t_in   i_in_data;
    logic           o_out_valid;
    logic           i_out_stall = 1'b0;
    cds_pkg::t_out  o_out_data;

    calendar_date_stepper_unit #(
        .FIRST_YEAR (FIRST_YEAR),
        .LAST_YEAR  (LAST_YEAR),
        .COUNT_BITS (16)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // date held by the predictor
    logic [cds_pkg::MONTH_W-1:0] held_month;
    logic [cds_pkg::DAY_W-1:0]   held_day;
    logic [cds_pkg::YEAR_W-1:0]  held_year;

    cds_pkg::t_out date_q[$];
    int   errors      = 0;
    int   idle_pct    = 18;
    int   hold_reqs   = 0;
    int   hold_seen   = 0;
    int   hold_left   = 0;
    int   loads_sent  = 0;
    int   walks_sent  = 0;
    int   limit_hits  = 0;
    int   days_walked = 0;

    function automatic bit leap_year(input int y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int month_days(input int m, input int y);
        case (m)
            2:             return leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    function automatic bit day_forward();
        if (held_day < month_days(held_month, held_year)) begin
            held_day = held_day + 1'b1;
        end else if (held_month < cds_pkg::MONTH_DEC) begin
            held_month = held_month + 1'b1;
            held_day   = cds_pkg::DAY_FIRST;
        end else begin
            if (held_year >= LAST_YEAR) begin
                return 1'b0;
            end
            held_year  = held_year + 1'b1;
            held_month = cds_pkg::MONTH_JAN;
            held_day   = cds_pkg::DAY_FIRST;
        end
        return 1'b1;
    endfunction

    function automatic bit day_back();
        if (held_day > cds_pkg::DAY_FIRST) begin
            held_day = held_day - 1'b1;
        end else if (held_month > cds_pkg::MONTH_JAN) begin
            held_month = held_month - 1'b1;
            held_day   = cds_pkg::DAY_W'(month_days(held_month, held_year));
        end else begin
            if (held_year <= FIRST_YEAR) begin
                return 1'b0;
            end
            held_year  = held_year - 1'b1;
            held_month = cds_pkg::MONTH_DEC;
            held_day   = cds_pkg::DAY_DEC31;
        end
        return 1'b1;
    endfunction

    function automatic cds_pkg::t_out apply_command(input cds_pkg::t_in beat);
        cds_pkg::t_out              res;
        logic [cds_pkg::STAT_W-1:0] stat;
        int                         steps;
        bit                         moved;
        stat  = cds_pkg::STAT_OK;
        steps = 0;
        case (beat.command)
            cds_pkg::CMD_LOAD: begin
                loads_sent++;
                if (beat.load_month < cds_pkg::MONTH_JAN ||
                    beat.load_month > cds_pkg::MONTH_DEC) begin
                    stat = cds_pkg::STAT_BAD_MONTH;
                end else if (beat.load_year < FIRST_YEAR || beat.load_year > LAST_YEAR) begin
                    stat = cds_pkg::STAT_BAD_YEAR;
                end else if (beat.load_day < cds_pkg::DAY_FIRST ||
                             beat.load_day > month_days(beat.load_month, beat.load_year)) begin
                    stat = cds_pkg::STAT_BAD_DAY;
                end else begin
                    held_month = beat.load_month;
                    held_day   = beat.load_day;
                    held_year  = beat.load_year;
                end
            end
            cds_pkg::CMD_ADVANCE, cds_pkg::CMD_BACK: begin
                walks_sent++;
                while (steps < beat.day_count && stat == cds_pkg::STAT_OK) begin
                    moved = (beat.command == cds_pkg::CMD_ADVANCE) ? day_forward()
                                                                   : day_back();
                    if (moved) begin
                        steps++;
                    end else begin
                        stat = cds_pkg::STAT_LIMIT;
                        limit_hits++;
                    end
                end
                days_walked += steps;
            end
            default: ;
        endcase
        res.month_now = held_month;
        res.day_now   = held_day;
        res.year_now  = held_year;
        res.status    = stat;
        return res;
    endfunction

    // result side: random stall, or a long hold counted here when a test asks for one
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen   <= hold_reqs;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_stall <= (idle_pct != 0) && ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        cds_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (date_q.size() == 0) begin
                $error("result beat with nothing expected: %p", o_out_data);
                errors++;
            end else begin
                want = date_q.pop_front();
                if (o_out_data.month_now !== want.month_now) begin
                    $error("month_now: expected %0d, got %0d", want.month_now,
                           o_out_data.month_now);
                    errors++;
                end
                if (o_out_data.day_now !== want.day_now) begin
                    $error("day_now: expected %0d, got %0d", want.day_now, o_out_data.day_now);
                    errors++;
                end
                if (o_out_data.year_now !== want.year_now) begin
                    $error("year_now: expected %0d, got %0d", want.year_now,
                           o_out_data.year_now);
                    errors++;
                end
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                    errors++;
                end
            end
        end
    end

    task automatic send_beat(input logic [1:0] cmd, input int m, input int d, input int y,
                             input int n);
        cds_pkg::t_in beat;
        beat.command    = cmd;
        beat.load_month = cds_pkg::MONTH_W'(m);
        beat.load_day   = cds_pkg::DAY_W'(d);
        beat.load_year  = cds_pkg::YEAR_W'(y);
        beat.day_count  = cds_pkg::COUNT_W'(n);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        date_q.push_back(apply_command(beat));
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic test_reset_date();
        // zero count shows the date held after reset
        send_beat(cds_pkg::CMD_ADVANCE, 0, 0, 0, 0);
    endtask

    task automatic test_load_checks();
        send_beat(cds_pkg::CMD_LOAD, 0, 0, 0, 0);
        send_beat(cds_pkg::CMD_LOAD, 13, 1, 2000, 0);
        send_beat(cds_pkg::CMD_LOAD, 15, 31, 4095, MAX_COUNT);
        send_beat(cds_pkg::CMD_LOAD, 5, 3, FIRST_YEAR - 1, 0);
        send_beat(cds_pkg::CMD_LOAD, 1, 0, 4095, 0);
        send_beat(cds_pkg::CMD_LOAD, 4, 0, 2000, 0);
        send_beat(cds_pkg::CMD_LOAD, 4, 31, 2000, 0);
        send_beat(cds_pkg::CMD_LOAD, 12, 31, 2099, 0);
    endtask

    task automatic test_leap_rules();
        send_beat(cds_pkg::CMD_LOAD, 2, 29, 1900, 0);
        send_beat(cds_pkg::CMD_LOAD, 2, 29, 2100, 0);
        send_beat(cds_pkg::CMD_LOAD, 2, 29, 2023, 0);
        send_beat(cds_pkg::CMD_LOAD, 2, 29, 2000, 0);
        send_beat(cds_pkg::CMD_LOAD, 3, 10, 2024, 0);
        send_beat(cds_pkg::CMD_BACK, 0, 0, 0, 10);
        send_beat(cds_pkg::CMD_ADVANCE, 0, 0, 0, 1);
    endtask

    task automatic test_year_wrap();
        send_beat(cds_pkg::CMD_LOAD, 12, 31, 1999, 0);
        send_beat(cds_pkg::CMD_ADVANCE, 0, 0, 0, 1);
        send_beat(cds_pkg::CMD_BACK, 0, 0, 0, 1);
    endtask

    task automatic test_year_limits();
        send_beat(cds_pkg::CMD_LOAD, 12, 30, LAST_YEAR, 0);
        send_beat(cds_pkg::CMD_ADVANCE, 0, 0, 0, 5);
        send_beat(cds_pkg::CMD_LOAD, 1, 2, FIRST_YEAR, 0);
        send_beat(cds_pkg::CMD_BACK, 0, 0, 0, 5);
    endtask

    task automatic test_unused_command();
        send_beat(CMD_UNUSED, 15, 31, 4095, MAX_COUNT);
    endtask

    task automatic test_long_walks();
        send_beat(cds_pkg::CMD_ADVANCE, 0, 0, 0, MAX_COUNT);
        send_beat(cds_pkg::CMD_LOAD, 12, 31, LAST_YEAR, 0);
        send_beat(cds_pkg::CMD_BACK, 0, 0, 0, MAX_COUNT);
    endtask

    task automatic test_backpressure();
        // result side holds off long enough for the input to back up
        hold_reqs++;
        repeat (6) begin
            send_beat($urandom_range(1) ? cds_pkg::CMD_ADVANCE : cds_pkg::CMD_BACK,
                      $urandom_range(15), $urandom_range(31), $urandom_range(4095),
                      $urandom_range(3, 1));
        end
    endtask

    task automatic test_random_mix(input int beats);
        int pick;
        int m;
        int d;
        int y;
        int n;
        repeat (beats) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                pick = $urandom_range(99);
                if (pick < 15) begin
                    // near a year limit so later walks run into it
                    y = $urandom_range(1) ? $urandom_range(LAST_YEAR, LAST_YEAR - 1)
                                          : $urandom_range(FIRST_YEAR + 1, FIRST_YEAR);
                end else begin
                    y = $urandom_range(LAST_YEAR, FIRST_YEAR);
                end
                m = $urandom_range(12, 1);
                d = $urandom_range(month_days(m, y), 1);
                if (pick >= 80 && pick < 90) begin
                    d = $urandom_range(31, 28);
                end else if (pick >= 90) begin
                    m = $urandom_range(15);
                    d = $urandom_range(31);
                    y = $urandom_range(4095);
                end
                send_beat(cds_pkg::CMD_LOAD, m, d, y, $urandom_range(MAX_COUNT));
            end else if (pick < 95) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    n = $urandom_range(40);
                end else if (pick < 95) begin
                    n = $urandom_range(400);
                end else begin
                    n = $urandom_range(2000);
                end
                send_beat($urandom_range(1) ? cds_pkg::CMD_ADVANCE : cds_pkg::CMD_BACK,
                          $urandom_range(15), $urandom_range(31), $urandom_range(4095), n);
            end else begin
                send_beat(CMD_UNUSED, $urandom_range(15), $urandom_range(31),
                          $urandom_range(4095), $urandom_range(MAX_COUNT));
            end
        end
    endtask

    task automatic test_no_idle();
        idle_pct = 0;
        test_random_mix(30);
        idle_pct = 18;
    endtask

    initial begin
        held_month  = cds_pkg::MONTH_JAN;
        held_day    = cds_pkg::DAY_FIRST;
        held_year   = cds_pkg::YEAR_W'(FIRST_YEAR);
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_date();
        test_load_checks();
        test_leap_rules();
        test_year_wrap();
        test_year_limits();
        test_unused_command();
        test_long_walks();
        test_backpressure();
        test_random_mix(40);
        test_no_idle();

        i_in_valid <= 1'b0;
        while (date_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        $display("covered %0d loads and %0d walks (%0d days stepped, %0d stopped at a limit)",
                 loads_sent, walks_sent, days_walked, limit_hits);
        $display("including leap rules, year wrap, full-count walks and a long result hold");
        if (errors == 0) begin
            $display("calendar_date_stepper_unit: match");
        end else begin
            $display("calendar_date_stepper_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #25_000_000;
        $display("timed out with %0d results outstanding", date_q.size());
        $display("calendar_date_stepper_unit: mismatch");
        $finish;
    end

endmodule

/* sim.f */
hdl/cds_pkg.sv
hdl/cds_datapath.sv
hdl/cds_ctrl.sv
hdl/calendar_date_stepper_unit.sv
hdl/cds_checker.sv
dv/calendar_date_stepper_unit_tb.sv
